// File: sv/bst_pkg.sv
// ----------------------------------------------------------------------------
// bst_pkg: shared types and constants of the byte stuffing frame tx buffer
// Command codes, status codes, framing constants and the ring control word.
// ----------------------------------------------------------------------------
package bst_pkg;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned AVAIL_W = 9;

  localparam logic [CMD_W-1:0] CMD_PAYLOAD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_COMMIT  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FORWARD = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FLUSH   = 3'd4;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_ERR = 1'b1;

  localparam logic [BYTE_W-1:0] FRAME_TAG   = 8'hFF;
  localparam int unsigned       HEADER_BYTES = 2;
  localparam int unsigned       FRAME_LIMIT  = 255;

  // One ring operation per cycle; push, forward, flush and peek exclude each other.
  typedef struct packed {
    logic              push;
    logic [BYTE_W-1:0] push_byte;
    logic              fwd;
    logic              flush;
    logic              peek;
    logic [BYTE_W-1:0] off;
  } ring_ctrl_t;

endpackage

// File: sv/bst_in_if.sv
// ----------------------------------------------------------------------------
// bst_in_if: command channel
// Valid/ready channel carrying one command word per handshake.
// ----------------------------------------------------------------------------
interface bst_in_if;
  import bst_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [BYTE_W-1:0] data_byte;
  logic [BYTE_W-1:0] offset_or_count;

  modport source (output valid, output command, output data_byte, output offset_or_count,
                  input ready);
  modport sink   (input valid, input command, input data_byte, input offset_or_count,
                  output ready);
endinterface

// File: sv/bst_out_if.sv
// ----------------------------------------------------------------------------
// bst_out_if: result channel
// Valid/ready channel carrying one result word per handshake.
// ----------------------------------------------------------------------------
interface bst_out_if;
  import bst_pkg::*;

  logic               valid;
  logic               ready;
  logic               status;
  logic [BYTE_W-1:0]  read_byte;
  logic [AVAIL_W-1:0] bytes_available;

  modport source (output valid, output status, output read_byte, output bytes_available,
                  input ready);
  modport sink   (input valid, input status, input read_byte, input bytes_available,
                  output ready);
endinterface

// File: sv/bst_stage_buf.sv
// ----------------------------------------------------------------------------
// bst_stage_buf: staging memory
// Holds the payload bytes of the open message; one write and one registered read.
// ----------------------------------------------------------------------------
module bst_stage_buf #(
  parameter int unsigned DEPTH = 253,
  parameter int unsigned AW    = 8
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [bst_pkg::BYTE_W-1:0] wdata_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [bst_pkg::BYTE_W-1:0] rdata_o
);
  import bst_pkg::*;

  logic [BYTE_W-1:0] mem_q [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/bst_ring_buf.sv
// ----------------------------------------------------------------------------
// bst_ring_buf: byte ring with pointers
// Ring memory, read and write pointers and fill count; one operation a cycle.
// ----------------------------------------------------------------------------
module bst_ring_buf #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8,
  parameter int unsigned FW    = 9
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bst_pkg::ring_ctrl_t        ctrl_i,
  output logic [FW-1:0]              fill_o,
  output logic [bst_pkg::BYTE_W-1:0] rdata_o
);
  import bst_pkg::*;

  localparam int unsigned SW = ((AW > BYTE_W) ? AW : BYTE_W) + 1;

  logic [BYTE_W-1:0] mem_q [DEPTH];
  logic [BYTE_W-1:0] rdata_q;
  logic [AW-1:0]     rp_q, rp_d;
  logic [AW-1:0]     wp_q, wp_d;
  logic [FW-1:0]     fill_q, fill_d;
  logic [SW-1:0]     sum;
  logic [AW-1:0]     off_addr;

  // Read pointer plus offset, wrapped once; the offset never exceeds the fill.
  always_comb begin
    sum = SW'(rp_q) + SW'(ctrl_i.off);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    off_addr = sum[AW-1:0];
  end

  always_comb begin
    rp_d   = rp_q;
    wp_d   = wp_q;
    fill_d = fill_q;
    if (ctrl_i.push) begin
      wp_d   = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
      fill_d = fill_q + FW'(1);
    end else if (ctrl_i.fwd) begin
      rp_d   = off_addr;
      fill_d = fill_q - FW'(ctrl_i.off);
    end else if (ctrl_i.flush) begin
      rp_d   = wp_q;
      fill_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q   <= '0;
      wp_q   <= '0;
      fill_q <= '0;
    end else begin
      rp_q   <= rp_d;
      wp_q   <= wp_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem_q[wp_q] <= ctrl_i.push_byte;
    end
    if (ctrl_i.peek) begin
      rdata_q <= mem_q[off_addr];
    end
  end

  assign fill_o  = fill_q;
  assign rdata_o = rdata_q;

endmodule

// File: sv/byte_stuffing_frame_tx_buffer.sv
// ----------------------------------------------------------------------------
// byte_stuffing_frame_tx_buffer: stuffed frame builder in front of a byte ring
// Stages payload bytes, builds 0xFF / length / stuffed payload frames into a
// ring on commit, and serves peek, forward and flush on the ring.
// ----------------------------------------------------------------------------
//
//  port   | dir | word fields                                   | role
//  -------+-----+-----------------------------------------------+-----------------
//  in_i   | in  | command, data_byte, offset_or_count           | one command
//  out_o  | out | status, read_byte, bytes_available            | one result each
//
//  Payload byte, forward, flush and errors: a registered result; peek: through
//  a registered ring read; commit: 0xFF, length, then the payload with each 0xFF
//  doubled, one ring byte per cycle by the copy sequencer through a single ring
//  write port. After a taken result, the next word is accepted the next cycle.
//  Reset clears the pointers, fill count and staging counts; memories are not
//  cleared. A stalled result holds, and no word is accepted until it is taken.
//
module byte_stuffing_frame_tx_buffer #(
  parameter int unsigned RING_DEPTH  = 256,
  parameter int unsigned MAX_PAYLOAD = 253
) (
  input logic        clk_i,
  input logic        rst_ni,
  bst_in_if.sink     in_i,
  bst_out_if.source  out_o
);
  import bst_pkg::*;

  localparam int unsigned RAW    = $clog2(RING_DEPTH);
  localparam int unsigned FW     = $clog2(RING_DEPTH + 1);
  localparam int unsigned CW     = (FW > 10) ? FW : 10;
  localparam int unsigned STG_AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_HDR  = 5'b00010,
    S_COPY = 5'b00100,
    S_ESC  = 5'b01000,
    S_PEEK = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [BYTE_W-1:0]   sc_q, sc_d;      // staged payload bytes
  logic [BYTE_W-1:0]   ec_q, ec_d;      // staged 0xFF bytes
  logic [BYTE_W-1:0]   cp_q, cp_d;      // payload bytes copied so far
  logic [BYTE_W-1:0]   cp_next;
  logic                out_valid_q, out_valid_d;
  logic                out_status_q, out_status_d;
  logic [BYTE_W-1:0]   out_rbyte_q, out_rbyte_d;

  logic                accept;
  logic                res_set;
  logic                res_status;
  logic                commit_err;
  logic [CW-1:0]       fill_ext, free_ext, total_ext, off_ext;

  ring_ctrl_t          ring_ctrl;
  logic [FW-1:0]       fill;
  logic [BYTE_W-1:0]   ring_rdata;

  logic                stg_we, stg_re;
  logic [STG_AW-1:0]   stg_raddr;
  logic [BYTE_W-1:0]   stg_rdata;

  bst_stage_buf #(
    .DEPTH (MAX_PAYLOAD),
    .AW    (STG_AW)
  ) u_stage (
    .clk_i   (clk_i),
    .we_i    (stg_we),
    .waddr_i (sc_q[STG_AW-1:0]),
    .wdata_i (in_i.data_byte),
    .re_i    (stg_re),
    .raddr_i (stg_raddr),
    .rdata_o (stg_rdata)
  );

  bst_ring_buf #(
    .DEPTH (RING_DEPTH),
    .AW    (RAW),
    .FW    (FW)
  ) u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ring_ctrl),
    .fill_o  (fill),
    .rdata_o (ring_rdata)
  );

  // Accept only from idle with the result register empty.
  assign in_i.ready = (state_q == S_IDLE) && !out_valid_q;
  assign accept     = in_i.valid && in_i.ready;

  // Frame size and room checks for commit.
  assign fill_ext   = CW'(fill);
  assign free_ext   = CW'(RING_DEPTH) - fill_ext;
  assign total_ext  = CW'(HEADER_BYTES) + CW'(sc_q) + CW'(ec_q);
  assign off_ext    = CW'(in_i.offset_or_count);
  assign commit_err = (sc_q > BYTE_W'(MAX_PAYLOAD)) || (total_ext > CW'(FRAME_LIMIT)) ||
                      (free_ext < total_ext);
  assign cp_next    = cp_q + BYTE_W'(1);

  always_comb begin
    state_d      = state_q;
    sc_d         = sc_q;
    ec_d         = ec_q;
    cp_d         = cp_q;
    res_set      = 1'b0;
    res_status   = ST_OK;
    out_rbyte_d  = '0;
    stg_we       = 1'b0;
    stg_re       = 1'b0;
    stg_raddr    = '0;
    ring_ctrl    = '0;
    ring_ctrl.off = in_i.offset_or_count;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_i.command)
            CMD_PAYLOAD: begin
              res_set = 1'b1;
              if (sc_q < BYTE_W'(MAX_PAYLOAD)) begin
                stg_we = 1'b1;
                sc_d   = sc_q + BYTE_W'(1);
                if (in_i.data_byte == FRAME_TAG) begin
                  ec_d = ec_q + BYTE_W'(1);
                end
              end else begin
                // Staging full: mark the message too long.
                res_status = ST_ERR;
                sc_d       = BYTE_W'(MAX_PAYLOAD + 1);
              end
            end
            CMD_COMMIT: begin
              if (commit_err) begin
                res_set    = 1'b1;
                res_status = ST_ERR;
                sc_d       = '0;
                ec_d       = '0;
              end else begin
                ring_ctrl.push      = 1'b1;
                ring_ctrl.push_byte = FRAME_TAG;
                state_d             = S_HDR;
              end
            end
            CMD_PEEK: begin
              if (off_ext < fill_ext) begin
                ring_ctrl.peek = 1'b1;
                state_d        = S_PEEK;
              end else begin
                res_set    = 1'b1;
                res_status = ST_ERR;
              end
            end
            CMD_FORWARD: begin
              res_set = 1'b1;
              if (off_ext <= fill_ext) begin
                ring_ctrl.fwd = 1'b1;
              end else begin
                res_status = ST_ERR;
              end
            end
            CMD_FLUSH: begin
              res_set         = 1'b1;
              ring_ctrl.flush = 1'b1;
            end
            default: begin
              res_set    = 1'b1;
              res_status = ST_ERR;
            end
          endcase
        end
      end
      S_HDR: begin
        // Length byte holds the stuffed payload length.
        ring_ctrl.push      = 1'b1;
        ring_ctrl.push_byte = sc_q + ec_q;
        if (sc_q == '0) begin
          res_set = 1'b1;
          sc_d    = '0;
          ec_d    = '0;
          state_d = S_IDLE;
        end else begin
          stg_re    = 1'b1;
          stg_raddr = '0;
          cp_d      = '0;
          state_d   = S_COPY;
        end
      end
      S_COPY, S_ESC: begin
        ring_ctrl.push      = 1'b1;
        ring_ctrl.push_byte = (state_q == S_ESC) ? FRAME_TAG : stg_rdata;
        if (state_q == S_COPY && stg_rdata == FRAME_TAG) begin
          // Double the tag byte on the next cycle.
          state_d = S_ESC;
        end else begin
          cp_d = cp_next;
          if (cp_next == sc_q) begin
            res_set = 1'b1;
            sc_d    = '0;
            ec_d    = '0;
            state_d = S_IDLE;
          end else begin
            stg_re    = 1'b1;
            stg_raddr = cp_next[STG_AW-1:0];
            state_d   = S_COPY;
          end
        end
      end
      S_PEEK: begin
        res_set     = 1'b1;
        out_rbyte_d = ring_rdata;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    if (res_set) begin
      out_valid_d  = 1'b1;
      out_status_d = res_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sc_q        <= '0;
      ec_q        <= '0;
      cp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sc_q        <= sc_d;
      ec_q        <= ec_d;
      cp_q        <= cp_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the result payload until the next result is formed.
  always_ff @(posedge clk_i) begin
    if (res_set) begin
      out_status_q <= out_status_d;
      out_rbyte_q  <= out_rbyte_d;
    end
  end

  // Fill count cannot move while a result waits, so show it directly.
  assign out_o.valid           = out_valid_q;
  assign out_o.status          = out_status_q;
  assign out_o.read_byte       = out_rbyte_q;
  assign out_o.bytes_available = fill_ext[AVAIL_W-1:0];

endmodule
